// ===== hw/rtl/tcw_pkg.sv =====
// shared types and constants of the text console writer
// no dependencies
package tcw_pkg;

  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CROW_W  = 5;
  localparam int CCOL_W  = 7;
  localparam int LIN_W   = 11;
  localparam int DATA_W  = 16;

  localparam logic [KIND_W-1:0] KIND_PRINT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NULL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [DATA_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [DATA_W-1:0] CLEAR_CELL = 16'h0000;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOR = 1'b0;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHAR,
    OP_TAB,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_RUN,
    ST_READ,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] cell_color;
    logic [CROW_W-1:0]  cell_row;
    logic [CCOL_W-1:0]  cell_col;
  } item_t;

  typedef struct packed {
    logic init_done;
    logic busy;
  } back_stat_t;

endpackage

// ===== hw/rtl/tcw_if.sv =====
// input and result channel interfaces of the text console writer
// depends on tcw_pkg
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::KIND_W-1:0]   kind;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::COLOR_W-1:0]  cell_color;
  logic [tcw_pkg::CROW_W-1:0]   cell_row;
  logic [tcw_pkg::CCOL_W-1:0]   cell_col;

  modport source (output valid, kind, char_code, cell_color, cell_row, cell_col,
                  input ready);
  modport sink (input valid, kind, char_code, cell_color, cell_row, cell_col,
                output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CROW_W-1:0]   cursor_row;
  logic [tcw_pkg::CCOL_W-1:0]   cursor_column;
  logic [tcw_pkg::LIN_W-1:0]    cursor_linear;
  logic [tcw_pkg::DATA_W-1:0]   read_data;

  modport source (output valid, cursor_row, cursor_column, cursor_linear, read_data,
                  input ready);
  modport sink (input valid, cursor_row, cursor_column, cursor_linear, read_data,
                output ready);
endinterface

// ===== hw/rtl/tcw_front.sv =====
// front end: takes input transfers and classifies them into operations
// depends on tcw_pkg and tcw_if
module tcw_front #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  tcw_in_if.sink              in_ch,
  input  tcw_pkg::back_stat_t stat_i,
  input  logic                full_i,
  output logic                push_o,
  output tcw_pkg::item_t      item_o
);

  logic in_range;

  assign in_range = (int'(in_ch.cell_row) < ROWS) && (int'(in_ch.cell_col) < COLS);

  assign in_ch.ready = !full_i && stat_i.init_done;
  assign push_o      = in_ch.valid && in_ch.ready;

  always_comb begin
    item_o.char_code  = in_ch.char_code;
    item_o.cell_color = in_ch.cell_color;
    item_o.cell_row   = in_ch.cell_row;
    item_o.cell_col   = in_ch.cell_col;
    item_o.op         = tcw_pkg::OP_NOP;
    unique case (in_ch.kind)
      tcw_pkg::KIND_PRINT: begin
        unique case (in_ch.char_code)
          tcw_pkg::CH_NULL:      item_o.op = tcw_pkg::OP_NOP;
          tcw_pkg::CH_TAB:       item_o.op = tcw_pkg::OP_TAB;
          tcw_pkg::CH_NEWLINE:   item_o.op = tcw_pkg::OP_NEWLINE;
          tcw_pkg::CH_BACKSPACE: item_o.op = tcw_pkg::OP_BACKSPACE;
          default:               item_o.op = tcw_pkg::OP_CHAR;
        endcase
      end
      // out of range cells: write ignored, read returns zero
      tcw_pkg::KIND_WRITE: item_o.op = in_range ? tcw_pkg::OP_WRITE : tcw_pkg::OP_NOP;
      tcw_pkg::KIND_READ:  item_o.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      default:             item_o.op = tcw_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/tcw_queue.sv =====
// short fifo of classified operations between front and back end
// depends on tcw_pkg
module tcw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcw_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcw_pkg::item_t item_o
);

  tcw_pkg::item_t                entry_q [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tcw_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tcw_pkg::QPTR_W:0]      count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// back end: cursor, screen memory with ring row offset, scroll clear, result register
// depends on tcw_pkg and tcw_if
module tcw_back #(
  parameter int ROWS     = 25,
  parameter int COLS     = 80,
  parameter int TAB_STOP = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tcw_pkg::COLOR_W-1:0]  text_color_i,
  input  logic                         q_valid_i,
  input  tcw_pkg::item_t               q_item_i,
  output logic                         q_pop_o,
  output tcw_pkg::back_stat_t          stat_o,
  tcw_out_if.source                    out_ch
);

  localparam int RW    = $clog2(ROWS);
  localparam int RXW   = RW + 1;
  localparam int CW    = $clog2(COLS);
  localparam int NCW   = $clog2(COLS + TAB_STOP + 1);
  localparam int TW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);

  tcw_pkg::state_e state_q, state_d;

  logic [RW-1:0]  cur_row_q, cur_row_d;
  logic [CW-1:0]  cur_col_q, cur_col_d;
  logic [TW-1:0]  phase_q, phase_d;
  logic [RW-1:0]  top_q, top_d;
  logic [AW-1:0]  sweep_q, sweep_d;
  logic [AW-1:0]  sweep_last_q, sweep_last_d;
  logic           out_valid_q, out_valid_d;

  logic [tcw_pkg::CROW_W-1:0] out_row_q, out_row_d;
  logic [tcw_pkg::CCOL_W-1:0] out_col_q, out_col_d;
  logic [tcw_pkg::LIN_W-1:0]  out_lin_q, out_lin_d;
  logic [tcw_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic                       out_load;

  logic [tcw_pkg::DATA_W-1:0] screen_q [CELLS];
  logic [tcw_pkg::DATA_W-1:0] rdata_q;

  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::DATA_W-1:0] mem_wdata;

  logic                       slot_free, fire, sweep_done;
  logic [NCW-1:0]             ncol;
  logic [RXW-1:0]             nrow;
  logic [TW-1:0]              nphase;
  logic                       scroll;
  logic                       cell_we, cell_re;
  logic [RW-1:0]              cell_row;
  logic [CW-1:0]              cell_col;
  logic [tcw_pkg::DATA_W-1:0] cell_data;
  logic [RXW-1:0]             prow_sum;
  logic [RW-1:0]              prow;
  logic [AW-1:0]              cell_addr;
  logic [AW-1:0]              lin;
  logic [AW-1:0]              lin_cur;
  logic [AW-1:0]              clr_base;

  assign slot_free  = !out_valid_q || out_ch.ready;
  assign fire       = (state_q == tcw_pkg::ST_RUN) && q_valid_i && slot_free;
  assign sweep_done = (sweep_q == sweep_last_q);
  assign q_pop_o    = fire;

  assign stat_o.init_done = (state_q != tcw_pkg::ST_INIT);
  assign stat_o.busy      = (state_q != tcw_pkg::ST_RUN);

  // cursor update for one operation
  always_comb begin
    ncol      = NCW'(cur_col_q);
    nrow      = RXW'(cur_row_q);
    nphase    = phase_q;
    cell_we   = 1'b0;
    cell_re   = 1'b0;
    cell_row  = cur_row_q;
    cell_col  = cur_col_q;
    cell_data = {text_color_i, q_item_i.char_code};
    scroll    = 1'b0;
    unique case (q_item_i.op)
      tcw_pkg::OP_CHAR: begin
        cell_we = 1'b1;
        ncol    = NCW'(cur_col_q) + 1'b1;
        nphase  = (phase_q == TW'(TAB_STOP-1)) ? '0 : phase_q + 1'b1;
      end
      tcw_pkg::OP_TAB: begin
        ncol   = NCW'(cur_col_q) + NCW'(TAB_STOP) - NCW'(phase_q);
        nphase = '0;
      end
      tcw_pkg::OP_NEWLINE: begin
        nrow   = RXW'(cur_row_q) + 1'b1;
        ncol   = '0;
        nphase = '0;
      end
      tcw_pkg::OP_BACKSPACE: begin
        if (cur_col_q != '0) begin
          ncol   = NCW'(cur_col_q) - 1'b1;
          nphase = (phase_q == '0) ? TW'(TAB_STOP-1) : phase_q - 1'b1;
        end
        cell_we   = 1'b1;
        cell_col  = ncol[CW-1:0];
        cell_data = {text_color_i, tcw_pkg::CH_SPACE};
      end
      tcw_pkg::OP_WRITE: begin
        cell_we   = 1'b1;
        cell_row  = RW'(q_item_i.cell_row);
        cell_col  = CW'(q_item_i.cell_col);
        cell_data = {q_item_i.cell_color, q_item_i.char_code};
      end
      tcw_pkg::OP_READ: begin
        cell_re  = 1'b1;
        cell_row = RW'(q_item_i.cell_row);
        cell_col = CW'(q_item_i.cell_col);
      end
      default: begin
      end
    endcase
    if (ncol >= NCW'(COLS)) begin
      ncol   = '0;
      nphase = '0;
      nrow   = nrow + 1'b1;
    end
    if (nrow >= RXW'(ROWS)) begin
      nrow   = RXW'(ROWS-1);
      scroll = 1'b1;
    end
  end

  // logical row to physical row through the ring offset
  always_comb begin
    prow_sum  = RXW'(cell_row) + RXW'(top_q);
    prow      = (prow_sum >= RXW'(ROWS)) ? RW'(prow_sum - RXW'(ROWS)) : RW'(prow_sum);
    cell_addr = AW'(prow) * AW'(COLS) + AW'(cell_col);
    lin       = AW'(nrow[RW-1:0]) * AW'(COLS) + AW'(ncol[CW-1:0]);
    lin_cur   = AW'(cur_row_q) * AW'(COLS) + AW'(cur_col_q);
    clr_base  = AW'(top_q) * AW'(COLS);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_INIT: begin
        if (sweep_done) begin
          state_d = tcw_pkg::ST_RUN;
        end
      end
      tcw_pkg::ST_RUN: begin
        if (fire && cell_re) begin
          state_d = tcw_pkg::ST_READ;
        end else if (fire && scroll) begin
          state_d = tcw_pkg::ST_CLEAR;
        end
      end
      tcw_pkg::ST_READ: state_d = tcw_pkg::ST_RUN;
      tcw_pkg::ST_CLEAR: begin
        if (sweep_done) begin
          state_d = tcw_pkg::ST_RUN;
        end
      end
      default: state_d = tcw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cell_addr;
    mem_wdata    = cell_data;
    sweep_d      = sweep_q;
    sweep_last_d = sweep_last_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    phase_d      = phase_q;
    top_d        = top_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    out_load     = 1'b0;
    out_row_d    = tcw_pkg::CROW_W'(nrow[RW-1:0]);
    out_col_d    = tcw_pkg::CCOL_W'(ncol[CW-1:0]);
    out_lin_d    = tcw_pkg::LIN_W'(lin);
    out_data_d   = '0;
    unique case (state_q)
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = tcw_pkg::RESET_CELL;
        sweep_d   = sweep_q + 1'b1;
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = tcw_pkg::CLEAR_CELL;
        sweep_d   = sweep_q + 1'b1;
      end
      tcw_pkg::ST_READ: begin
        out_valid_d = 1'b1;
        out_load    = 1'b1;
        out_row_d   = tcw_pkg::CROW_W'(cur_row_q);
        out_col_d   = tcw_pkg::CCOL_W'(cur_col_q);
        out_lin_d   = tcw_pkg::LIN_W'(lin_cur);
        out_data_d  = rdata_q;
      end
      tcw_pkg::ST_RUN: begin
        if (fire) begin
          mem_we    = cell_we;
          mem_re    = cell_re;
          cur_row_d = nrow[RW-1:0];
          cur_col_d = ncol[CW-1:0];
          phase_d   = nphase;
          if (!cell_re) begin
            out_valid_d = 1'b1;
            out_load    = 1'b1;
          end
          if (scroll) begin
            // old top row becomes the cleared bottom row
            top_d        = (top_q == RW'(ROWS-1)) ? '0 : top_q + 1'b1;
            sweep_d      = clr_base;
            sweep_last_d = clr_base + AW'(COLS-1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tcw_pkg::ST_INIT;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      phase_q      <= '0;
      top_q        <= '0;
      sweep_q      <= '0;
      sweep_last_q <= AW'(CELLS-1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      phase_q      <= phase_d;
      top_q        <= top_d;
      sweep_q      <= sweep_d;
      sweep_last_q <= sweep_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_lin_q  <= out_lin_d;
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= screen_q[cell_addr];
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.cursor_row    = out_row_q;
  assign out_ch.cursor_column = out_col_q;
  assign out_ch.cursor_linear = out_lin_q;
  assign out_ch.read_data     = out_data_q;

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_row_q) < ROWS)
    else $error("cursor row out of range");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_col_q) < COLS)
    else $error("cursor column out of range");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_READ |=> out_ch.valid)
    else $error("cell read gave no result");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_INIT |-> !out_ch.valid && !q_pop_o)
    else $error("activity during screen fill");

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// text console writer top level: apb register, front end, queue, back end
// depends on tcw_pkg, tcw_if, tcw_front, tcw_queue, tcw_back
// path: queue entry, then result register; a cell read also passes the memory read register
// throughput: 1 item per cycle unless the output stalls; a cell read holds the back end (memory read port)
// a scroll clears the new bottom row in the screen memory before the next item is taken
// reset: screen fill of ROWS*COLS cells, no input taken meanwhile
module text_console_writer #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  tcw_in_if.sink                            in_i,
  tcw_out_if.source                         out_o
);

  logic [tcw_pkg::COLOR_W-1:0]   text_color_q;
  logic [tcw_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          reg_wr;

  logic                          push, full, q_valid, q_pop;
  tcw_pkg::item_t                push_item, q_item;
  tcw_pkg::back_stat_t           stat;

  assign reg_idx = paddr[tcw_pkg::APB_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready && (reg_idx == tcw_pkg::REG_TEXT_COLOR);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == tcw_pkg::REG_TEXT_COLOR) ?
                   tcw_pkg::APB_DATA_W'(text_color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::TEXT_COLOR_RESET;
    end else if (reg_wr) begin
      text_color_q <= pwdata[tcw_pkg::COLOR_W-1:0];
    end
  end

  tcw_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .in_ch  (in_i),
    .stat_i (stat),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tcw_back #(
    .ROWS     (ROWS),
    .COLS     (COLS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .stat_o       (stat),
    .out_ch       (out_o)
  );

endmodule
